[sv/elufb_pkg.sv]
// Shared types, constants and helper functions of the ELU forward and backward unit.
package elufb_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 10;

	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 12;
	localparam int ACC_W      = 32;
	localparam int WIDE_W     = 2 * ACC_W;
	localparam int U_W        = WIDE_W - 1;
	localparam int LOG2E_FRAC = 30;
	localparam int TAB_W      = 18;
	localparam int TAB_FRAC   = 16;
	localparam int TAB_IDX_W  = 5;
	localparam int DIFF_W     = 13;
	localparam int R16_W      = 16;
	localparam int IP_W       = DIFF_W + R16_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int MODE_W     = 2;

	localparam int PIPE_STAGES = 8;

	localparam logic signed [ACC_W-1:0] LOG2E_Q30 = 32'sd1549082005;
	localparam logic signed [ACC_W-1:0] ACC_HI = 32'sh7FFF_FFFF;
	localparam logic signed [ACC_W-1:0] ACC_LO = 32'sh8000_0000;
	localparam logic signed [WIDE_W-1:0] ACC_HI_W = 64'sh0000_0000_7FFF_FFFF;
	localparam logic signed [WIDE_W-1:0] ACC_LO_W = 64'shFFFF_FFFF_8000_0000;

	typedef enum logic [MODE_W-1:0] {
		MODE_FWD     = 2'd0,
		MODE_BWD_IN  = 2'd1,
		MODE_BWD_OUT = 2'd2
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 2'd0,
		REG_ALPHA  = 2'd1,
		REG_SCALE  = 2'd2,
		REG_ISCALE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [MODE_W-1:0]        mode;
		logic signed [COEF_W-1:0] alpha;
		logic signed [COEF_W-1:0] scale;
		logic signed [COEF_W-1:0] iscale;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		mode:   MODE_FWD,
		alpha:  16'sd4096,
		scale:  16'sd4096,
		iscale: 16'sd4096
	};

	typedef struct packed {
		logic [PIPE_STAGES-1:0] adv;
	} pipe_ctrl_t;

	// 2^(i/16) in Q16, seventeen points so that the last interval has an upper end.
	function automatic logic [TAB_W-1:0] pow2_tab(input logic [TAB_IDX_W-1:0] i);
		logic [TAB_W-1:0] v;
		case (i)
			5'd0:    v = 18'd65536;
			5'd1:    v = 18'd68438;
			5'd2:    v = 18'd71468;
			5'd3:    v = 18'd74632;
			5'd4:    v = 18'd77936;
			5'd5:    v = 18'd81386;
			5'd6:    v = 18'd84990;
			5'd7:    v = 18'd88752;
			5'd8:    v = 18'd92682;
			5'd9:    v = 18'd96785;
			5'd10:   v = 18'd101070;
			5'd11:   v = 18'd105545;
			5'd12:   v = 18'd110218;
			5'd13:   v = 18'd115098;
			5'd14:   v = 18'd120194;
			5'd15:   v = 18'd125515;
			5'd16:   v = 18'd131072;
			default: v = 18'd0;
		endcase
		return v;
	endfunction

	// Right shift that rounds half up: add half an LSB, then floor.
	function automatic logic signed [WIDE_W-1:0] rnd_shr(input logic signed [WIDE_W-1:0] v,
		input int unsigned sh);
		logic signed [WIDE_W:0] w;
		w = (WIDE_W+1)'(v);
		if (sh != 0) begin
			w = w + ((65'sd1) <<< (sh - 1));
		end
		return WIDE_W'(w >>> sh);
	endfunction

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [WIDE_W-1:0] v);
		logic signed [ACC_W-1:0] r;
		if (v > ACC_HI_W) begin
			r = ACC_HI;
		end else if (v < ACC_LO_W) begin
			r = ACC_LO;
		end else begin
			r = ACC_W'(v);
		end
		return r;
	endfunction

endpackage

[sv/elufb_cfg.sv]
// Configuration register file: mode and the three Q3.12 coefficients.
module elufb_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [elufb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [elufb_pkg::CFG_DATA_W-1:0]     cfg_data,
	output elufb_pkg::cfg_t                      cfg
);

	elufb_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= elufb_pkg::CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (elufb_pkg::reg_idx_t'(cfg_index))
				elufb_pkg::REG_MODE:   cfg_q.mode   <= cfg_data[elufb_pkg::MODE_W-1:0];
				elufb_pkg::REG_ALPHA:  cfg_q.alpha  <= $signed(cfg_data);
				elufb_pkg::REG_SCALE:  cfg_q.scale  <= $signed(cfg_data);
				elufb_pkg::REG_ISCALE: cfg_q.iscale <= $signed(cfg_data);
				default:               cfg_q        <= cfg_q;
			endcase
		end
	end

endmodule

[sv/elufb_ctrl.sv]
// Pipeline flow control: per-stage valid bits and advance enables with bubble collapsing.
module elufb_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output elufb_pkg::pipe_ctrl_t pipe
);

	localparam int NSTG = elufb_pkg::PIPE_STAGES;

	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] adv;

	// A stage may load when it is empty or when its item moves on in the same cycle.
	always_comb begin
		adv[NSTG-1] = !vld_q[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready  = adv[0];
	assign out_valid = vld_q[NSTG-1];
	assign pipe.adv  = adv;

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled although the output side is taking items");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> &vld_q)
		else $error("input stalled while a pipeline stage is empty");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> vld_q[0])
		else $error("accepted item did not enter the first stage");

	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !vld_q[NSTG-2] |=> !out_valid)
		else $error("output stayed valid with nothing behind it");

endmodule

[sv/elufb_dp.sv]
// Eight-stage ELU datapath: coefficient products, exponential by table and interpolation, final product.
module elufb_dp #(
	parameter int DATA_WIDTH = elufb_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = elufb_pkg::FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  elufb_pkg::pipe_ctrl_t        pipe,
	input  elufb_pkg::cfg_t              cfg,
	input  logic signed [DATA_WIDTH-1:0] first_value,
	input  logic signed [DATA_WIDTH-1:0] second_value,
	output logic signed [DATA_WIDTH-1:0] result_value
);

	localparam int DW     = DATA_WIDTH;
	localparam int PW     = DW + elufb_pkg::COEF_W;
	localparam int AW     = elufb_pkg::ACC_W;
	localparam int WW     = elufb_pkg::WIDE_W;
	localparam int UW     = elufb_pkg::U_W;
	localparam int K      = FRAC_BITS + elufb_pkg::LOG2E_FRAC;
	localparam int NW     = UW - K;
	localparam int SHW    = NW + 2;
	localparam int NEG_SH = 2 * elufb_pkg::COEF_FRAC - FRAC_BITS;
	localparam int TW     = elufb_pkg::TAB_W;

	localparam logic signed [SHW-1:0] EXP_OFS = SHW'(elufb_pkg::TAB_FRAC - FRAC_BITS);
	localparam logic signed [AW-1:0]  DATA_ONE = AW'(64'd1 << FRAC_BITS);
	localparam logic signed [WW-1:0]  DMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
	localparam logic signed [WW-1:0]  DMIN = -DMAX - 64'sd1;

	typedef struct packed {
		logic fwd;
		logic bin;
		logic pos;
	} flags_t;

	function automatic logic signed [DW-1:0] sat_data(input logic signed [WW-1:0] v);
		logic signed [DW-1:0] r;
		if (v > DMAX) begin
			r = DW'(DMAX);
		end else if (v < DMIN) begin
			r = DW'(DMIN);
		end else begin
			r = DW'(v);
		end
		return r;
	endfunction

	// Stage 1: input register.
	logic signed [DW-1:0] a_s1, b_s1;

	always_ff @(posedge clk) begin
		if (pipe.adv[0]) begin
			a_s1 <= first_value;
			b_s1 <= second_value;
		end
	end

	// Stage 2: coefficient products.
	flags_t               fl1;
	logic signed [DW-1:0] x1;
	logic signed [PW-1:0] arg_prod, g_prod, pos_prod;
	logic signed [AW-1:0] negcoef;

	always_comb begin
		fl1.fwd = 1'b0;
		fl1.bin = 1'b0;
		unique case (cfg.mode)
			elufb_pkg::MODE_FWD:    fl1.fwd = 1'b1;
			elufb_pkg::MODE_BWD_IN: fl1.bin = 1'b1;
			default:                fl1.bin = 1'b0;
		endcase
		x1      = fl1.fwd ? a_s1 : b_s1;
		fl1.pos = x1 > 0;
	end

	assign arg_prod = x1 * $signed(cfg.iscale);
	assign g_prod   = a_s1 * $signed(cfg.iscale);
	assign pos_prod = a_s1 * $signed(cfg.scale);
	assign negcoef  = $signed(cfg.alpha) * $signed(cfg.scale);

	logic signed [PW-1:0] arg_prod_s2, g_prod_s2, pos_prod_s2;
	logic signed [AW-1:0] negcoef_s2;
	logic signed [DW-1:0] b_s2;
	flags_t               fl_s2;

	always_ff @(posedge clk) begin
		if (pipe.adv[1]) begin
			arg_prod_s2 <= arg_prod;
			g_prod_s2   <= g_prod;
			pos_prod_s2 <= pos_prod;
			negcoef_s2  <= negcoef;
			b_s2        <= b_s1;
			fl_s2       <= fl1;
		end
	end

	// Stage 3: rounding and saturation of the products, shifted sum for the result-based gradient.
	logic signed [AW-1:0] t_s3, g_s3, s_s3, negcoef_s3;
	logic signed [DW-1:0] pos_r_s3;
	flags_t               fl_s3;

	always_ff @(posedge clk) begin
		if (pipe.adv[2]) begin
			t_s3       <= elufb_pkg::sat_acc(elufb_pkg::rnd_shr(WW'(arg_prod_s2),
				elufb_pkg::COEF_FRAC));
			g_s3       <= elufb_pkg::sat_acc(elufb_pkg::rnd_shr(WW'(g_prod_s2),
				elufb_pkg::COEF_FRAC));
			pos_r_s3   <= sat_data(elufb_pkg::rnd_shr(WW'(pos_prod_s2), elufb_pkg::COEF_FRAC));
			s_s3       <= elufb_pkg::sat_acc(WW'(b_s2)
				+ elufb_pkg::rnd_shr(WW'(negcoef_s2), NEG_SH));
			negcoef_s3 <= negcoef_s2;
			fl_s3      <= fl_s2;
		end
	end

	// Stage 4: base-2 exponent argument and the gradient product.
	logic signed [WW-1:0] u_full, gm_prod;
	logic signed [AW-1:0] gm_b;

	assign u_full  = t_s3 * elufb_pkg::LOG2E_Q30;
	assign gm_b    = fl_s3.bin ? negcoef_s3 : s_s3;
	assign gm_prod = g_s3 * gm_b;

	logic signed [UW-1:0] u_s4;
	logic signed [WW-1:0] gm_prod_s4;
	logic signed [AW-1:0] negcoef_s4;
	logic signed [DW-1:0] pos_r_s4;
	flags_t               fl_s4;

	always_ff @(posedge clk) begin
		if (pipe.adv[3]) begin
			u_s4       <= UW'(u_full);
			gm_prod_s4 <= gm_prod;
			negcoef_s4 <= negcoef_s3;
			pos_r_s4   <= pos_r_s3;
			fl_s4      <= fl_s3;
		end
	end

	// Stage 5: split into integer and fraction, table lookup and interpolation product.
	logic signed [NW-1:0]               n4;
	logic [K-1:0]                       frac4;
	logic [3:0]                         idx4;
	logic [elufb_pkg::R16_W-1:0]        r16;
	logic [TW-1:0]                      tab0, tab1;
	logic [elufb_pkg::DIFF_W-1:0]       diff;
	logic [elufb_pkg::IP_W-1:0]         ip;
	logic signed [SHW-1:0]              sh4;

	assign n4    = u_s4[UW-1:K];
	assign frac4 = u_s4[K-1:0];
	assign idx4  = frac4[K-1 -: 4];
	assign r16   = frac4[K-5 -: elufb_pkg::R16_W];
	assign tab0  = elufb_pkg::pow2_tab({1'b0, idx4});
	assign tab1  = elufb_pkg::pow2_tab({1'b0, idx4} + 5'd1);
	assign diff  = elufb_pkg::DIFF_W'(tab1 - tab0);
	assign ip    = diff * r16;
	assign sh4   = EXP_OFS - SHW'(n4);

	logic [TW-1:0]                tab0_s5;
	logic [elufb_pkg::IP_W-1:0]   ip_s5;
	logic signed [SHW-1:0]        sh_s5;
	logic signed [AW-1:0]         h_s5, negcoef_s5;
	logic signed [DW-1:0]         m2r_s5, pos_r_s5;
	flags_t                       fl_s5;

	always_ff @(posedge clk) begin
		if (pipe.adv[4]) begin
			tab0_s5    <= tab0;
			ip_s5      <= ip;
			sh_s5      <= sh4;
			h_s5       <= elufb_pkg::sat_acc(elufb_pkg::rnd_shr(gm_prod_s4,
				2 * elufb_pkg::COEF_FRAC));
			m2r_s5     <= sat_data(elufb_pkg::rnd_shr(gm_prod_s4, FRAC_BITS));
			negcoef_s5 <= negcoef_s4;
			pos_r_s5   <= pos_r_s4;
			fl_s5      <= fl_s4;
		end
	end

	// Stage 6: interpolated 2^f, scaled by 2^n into the data format.
	logic [elufb_pkg::IP_W:0] ip_rnd;
	logic [TW-1:0]            p5;
	logic [SHW-1:0]           nsh;
	logic [AW:0]              lsh_v;
	logic [TW:0]              rsh_v;
	logic signed [AW-1:0]     e5;

	assign ip_rnd = (elufb_pkg::IP_W+1)'(ip_s5) + (elufb_pkg::IP_W+1)'(32768);
	assign p5     = tab0_s5 + TW'(ip_rnd >> elufb_pkg::TAB_FRAC);
	assign nsh    = -sh_s5;
	assign lsh_v  = (AW+1)'(p5) << nsh[3:0];
	// A zero shift makes the half-LSB term shift out to zero.
	assign rsh_v  = ((TW+1)'(p5) + ((TW+1)'(1) << (sh_s5[4:0] - 5'd1))) >> sh_s5[4:0];

	always_comb begin
		if (sh_s5 < 0) begin
			if (sh_s5 <= -15) begin
				e5 = elufb_pkg::ACC_HI;
			end else if (lsh_v > (AW+1)'(elufb_pkg::ACC_HI)) begin
				e5 = elufb_pkg::ACC_HI;
			end else begin
				e5 = AW'(lsh_v);
			end
		end else if (sh_s5 > 18) begin
			e5 = '0;
		end else begin
			e5 = AW'(rsh_v);
		end
	end

	logic signed [AW-1:0] e_s6, h_s6, negcoef_s6;
	logic signed [DW-1:0] m2r_s6, pos_r_s6;
	flags_t               fl_s6;

	always_ff @(posedge clk) begin
		if (pipe.adv[5]) begin
			e_s6       <= e5;
			h_s6       <= h_s5;
			negcoef_s6 <= negcoef_s5;
			m2r_s6     <= m2r_s5;
			pos_r_s6   <= pos_r_s5;
			fl_s6      <= fl_s5;
		end
	end

	// Stage 7: forward uses expm1 times alpha*scale, input-based gradient uses the partial times exp.
	logic signed [AW-1:0] fm_a, fm_b;
	logic signed [WW-1:0] fm_prod;

	assign fm_a    = fl_s6.fwd ? (e_s6 - DATA_ONE) : h_s6;
	assign fm_b    = fl_s6.fwd ? negcoef_s6 : e_s6;
	assign fm_prod = fm_a * fm_b;

	logic signed [WW-1:0] fm_s7;
	logic signed [DW-1:0] m2r_s7, pos_r_s7;
	flags_t               fl_s7;

	always_ff @(posedge clk) begin
		if (pipe.adv[6]) begin
			fm_s7    <= fm_prod;
			m2r_s7   <= m2r_s6;
			pos_r_s7 <= pos_r_s6;
			fl_s7    <= fl_s6;
		end
	end

	// Stage 8: final rounding, saturation and branch selection into the output register.
	logic signed [DW-1:0] fm_r, res7;

	assign fm_r = fl_s7.fwd
		? sat_data(elufb_pkg::rnd_shr(fm_s7, 2 * elufb_pkg::COEF_FRAC))
		: sat_data(elufb_pkg::rnd_shr(fm_s7, FRAC_BITS));

	always_comb begin
		if (fl_s7.pos) begin
			res7 = pos_r_s7;
		end else if (fl_s7.fwd || fl_s7.bin) begin
			res7 = fm_r;
		end else begin
			res7 = m2r_s7;
		end
	end

	logic signed [DW-1:0] result_s8;

	always_ff @(posedge clk) begin
		if (pipe.adv[7]) begin
			result_s8 <= res7;
		end
	end

	assign result_value = result_s8;

endmodule

[sv/elu_activation_fwd_bwd_top.sv]
// Top level of the ELU forward and backward activation unit.
//
//  Channel | Signals                                   | Item taken when
//  --------+-------------------------------------------+-------------------------
//  in      | in_valid, in_ready, first_value,          | in_valid && in_ready
//          | second_value                              |
//  out     | out_valid, out_ready, result_value        | out_valid && out_ready
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid && cfg_ready
//
// One item per clock unless the output side stalls. Each item passes eight register stages;
// the depth is set by the 32x32 multipliers of the exponential and gradient paths, each
// followed by a register.
// Reset empties the pipeline and restores mode 0 with all coefficients at 1.0.
// A full stage holds while the stage after it is blocked; empty stages close up, so
// in_ready drops only when all eight stages hold items and out_ready is low.
module elu_activation_fwd_bwd_top #(
	parameter int DATA_WIDTH = elufb_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = elufb_pkg::FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic signed [DATA_WIDTH-1:0]         first_value,
	input  logic signed [DATA_WIDTH-1:0]         second_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [DATA_WIDTH-1:0]         result_value,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [elufb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [elufb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	elufb_pkg::cfg_t       cfg;
	elufb_pkg::pipe_ctrl_t pipe;

	elufb_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	elufb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pipe      (pipe)
	);

	elufb_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.pipe         (pipe),
		.cfg          (cfg),
		.first_value  (first_value),
		.second_value (second_value),
		.result_value (result_value)
	);

endmodule

[tb/sv/tb_elu_activation_fwd_bwd_top.sv]
// Self-checking testbench for the ELU forward and backward activation unit.
module tb_elu_activation_fwd_bwd_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW = elufb_pkg::DATA_WIDTH_DEF;
	localparam int FB = elufb_pkg::FRAC_BITS_DEF;
	localparam int MW = elufb_pkg::MODE_W;
	localparam int CW = elufb_pkg::COEF_W;
	localparam int CDW = elufb_pkg::CFG_DATA_W;
	localparam int CYCLE_LIMIT = 100000;
	localparam int RANDOM_PHASES = 10;
	localparam int ITEMS_PER_PHASE = 95;
	localparam longint LOG2E_FIX = 64'sd1549082005;
	localparam longint ACC_MAX = 64'sd2147483647;
	// Code 3 has no name in the package; the unit decodes it as backward from result.
	localparam logic [MW-1:0] MODE_RESERVED = 2'd3;

	// 2^(i/16) in Q16 with an upper end point for the last interval.
	localparam longint EXP2_POINTS [17] = '{
		65536, 68438, 71468, 74632, 77936, 81386, 84990, 88752,
		92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072
	};

	typedef struct {
		logic signed [DW-1:0] first;
		logic signed [DW-1:0] second;
	} elu_item_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [DW-1:0] first_value = '0;
	logic signed [DW-1:0] second_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [DW-1:0] result_value;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [elufb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [CDW-1:0] cfg_data = '0;

	// Register copies used for prediction.
	logic [MW-1:0] cur_mode = elufb_pkg::MODE_FWD;
	logic signed [CW-1:0] cur_alpha = 16'sd4096;
	logic signed [CW-1:0] cur_scale = 16'sd4096;
	logic signed [CW-1:0] cur_iscale = 16'sd4096;

	elu_item_t pending_items[$];
	logic signed [DW-1:0] expected_results[$];
	int error_count = 0;
	int cycle_count = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit quiet = 1'b0;

	elu_activation_fwd_bwd_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.first_value(first_value),
		.second_value(second_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_value(result_value),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint half_up_shift(input longint v, input int s);
		if (s == 0) begin
			return v;
		end
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi) begin
			return hi;
		end
		if (v < lo) begin
			return lo;
		end
		return v;
	endfunction

	// exp(t) with t and the result in data format: 2^(t*log2e) split into an
	// integer power and a fraction looked up in the table with interpolation.
	function automatic longint exp_fixed(input longint t);
		int k;
		longint u;
		longint n;
		longint frac;
		longint idx;
		longint r16;
		longint d;
		longint p;
		longint sh;
		k = FB + 30;
		u = t * LOG2E_FIX;
		n = u >>> k;
		frac = u - (n <<< k);
		idx = (frac >>> (k - 4)) & 64'sd15;
		r16 = (frac & ((longint'(1) <<< (k - 4)) - 1)) >>> (k - 20);
		d = EXP2_POINTS[int'(idx) + 1] - EXP2_POINTS[int'(idx)];
		p = EXP2_POINTS[int'(idx)] + ((d * r16 + 32768) >>> 16);
		sh = 16 - FB - n;
		if (sh < 0) begin
			if (sh <= -15) begin
				return ACC_MAX;
			end
			return clamp(p <<< int'(-sh), 32);
		end
		if (sh > 62) begin
			return 0;
		end
		return clamp(half_up_shift(p, int'(sh)), 32);
	endfunction

	function automatic longint exp_argument(input longint x);
		return clamp(half_up_shift(x * longint'(cur_iscale), elufb_pkg::COEF_FRAC), 32);
	endfunction

	function automatic logic signed [DW-1:0] predict_result(input logic signed [DW-1:0] fv,
		input logic signed [DW-1:0] sv);
		longint a;
		longint b;
		longint negcoef;
		longint r;
		longint e;
		longint g;
		longint h;
		longint s;
		a = fv;
		b = sv;
		negcoef = longint'(cur_alpha) * longint'(cur_scale);
		if (cur_mode == elufb_pkg::MODE_FWD) begin
			if (a > 0) begin
				r = half_up_shift(a * longint'(cur_scale), elufb_pkg::COEF_FRAC);
			end else begin
				e = clamp(exp_fixed(exp_argument(a)) - (longint'(1) <<< FB), 32);
				r = half_up_shift(e * negcoef, 2 * elufb_pkg::COEF_FRAC);
			end
		end else if (b > 0) begin
			r = half_up_shift(a * longint'(cur_scale), elufb_pkg::COEF_FRAC);
		end else begin
			g = clamp(half_up_shift(a * longint'(cur_iscale), elufb_pkg::COEF_FRAC), 32);
			if (cur_mode == elufb_pkg::MODE_BWD_IN) begin
				e = exp_fixed(exp_argument(b));
				h = clamp(half_up_shift(g * negcoef, 2 * elufb_pkg::COEF_FRAC), 32);
				r = half_up_shift(h * e, FB);
			end else begin
				s = clamp(b + half_up_shift(negcoef, 2 * elufb_pkg::COEF_FRAC - FB), 32);
				r = half_up_shift(g * s, FB);
			end
		end
		return DW'(clamp(r, DW));
	endfunction

	task automatic note_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	// Sender: presents queued items and predicts each one as it is taken.
	always @(posedge clk or negedge arst_n) begin : drive_items
		elu_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			first_value <= '0;
			second_value <= '0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_result(first_value, second_value));
			end
			if (!in_valid || in_ready) begin
				if (send_gap > 0 && !quiet) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					nxt = pending_items.pop_front();
					in_valid <= 1'b1;
					first_value <= nxt.first;
					second_value <= nxt.second;
					if (!quiet && $urandom_range(0, 99) < send_idle_pct) begin
						send_gap = $urandom_range(1, 5);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: checks each result against the oldest prediction and stalls at random.
	always @(posedge clk or negedge arst_n) begin : watch_results
		logic signed [DW-1:0] want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					note_mismatch($sformatf("result %0d with nothing expected", result_value));
				end else begin
					want = expected_results.pop_front();
					if (result_value !== want) begin
						note_mismatch($sformatf("result_value got %0d expected %0d (mode %0d)",
							result_value, want, cur_mode));
					end
				end
			end
			if (recv_stall > 0 && !quiet) begin
				recv_stall--;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 99) < recv_idle_pct) begin
				recv_stall = $urandom_range(0, 4);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Keeps cfg_valid high across back-to-back writes; the caller lowers it.
	task automatic write_reg(input elufb_pkg::reg_idx_t idx, input logic [CDW-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			elufb_pkg::REG_MODE:   cur_mode = val[MW-1:0];
			elufb_pkg::REG_ALPHA:  cur_alpha = val;
			elufb_pkg::REG_SCALE:  cur_scale = val;
			elufb_pkg::REG_ISCALE: cur_iscale = val;
			default:               ;
		endcase
	endtask

	task automatic set_config(input logic [MW-1:0] m, input logic signed [CW-1:0] al,
		input logic signed [CW-1:0] sc, input logic signed [CW-1:0] is,
		input logic [CDW-MW-1:0] pad);
		write_reg(elufb_pkg::REG_MODE, {pad, m});
		write_reg(elufb_pkg::REG_ALPHA, al);
		write_reg(elufb_pkg::REG_SCALE, sc);
		write_reg(elufb_pkg::REG_ISCALE, is);
		cfg_valid <= 1'b0;
	endtask

	// Holds until every queued item is taken and every result is back, then lets the
	// pipeline settle.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (elufb_pkg::PIPE_STAGES + 4) @(posedge clk);
	endtask

	task automatic queue_item(input int f, input int s);
		elu_item_t it;
		it.first = DW'(f);
		it.second = DW'(s);
		pending_items.push_back(it);
	endtask

	function automatic int rand_data();
		case ($urandom_range(0, 3))
			0: return int'(DW'($urandom));
			1: return int'($urandom_range(0, 8192)) - 6144;
			2: begin
				case ($urandom_range(0, 4))
					0: return -32768;
					1: return 32767;
					2: return 0;
					3: return -1;
					default: return 1;
				endcase
			end
			default: return int'($urandom_range(0, 2047)) - 1024;
		endcase
	endfunction

	function automatic logic signed [CW-1:0] rand_coef();
		case ($urandom_range(0, 3))
			0: return CW'($urandom);
			1: return CW'($urandom_range(0, 8192));
			2: begin
				case ($urandom_range(0, 4))
					0: return -16'sd32768;
					1: return 16'sd32767;
					2: return 16'sd0;
					3: return 16'sd4096;
					default: return -16'sd4096;
				endcase
			end
			default: return CW'(int'($urandom_range(0, 16384)) - 8192);
		endcase
	endfunction

	function automatic int rand_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 40;
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset coefficients; zero must take the negative branch.
		send_idle_pct = 20;
		recv_idle_pct = 20;
		queue_item(0, 0);
		queue_item(1, 0);
		queue_item(-1, 0);
		queue_item(32767, 0);
		queue_item(-32768, -1);
		queue_item(-1024, 7);
		queue_item(1024, 0);
		wait_idle();

		set_config(elufb_pkg::MODE_BWD_IN, 16'sd4096, 16'sd4096, 16'sd4096, '0);
		queue_item(1024, 0);
		queue_item(1024, 1);
		queue_item(32767, -32768);
		queue_item(-32768, 32767);
		queue_item(-32768, -32768);
		wait_idle();

		set_config(elufb_pkg::MODE_BWD_OUT, 16'sd4096, 16'sd4096, 16'sd4096, '0);
		queue_item(1024, 0);
		queue_item(32767, -32768);
		queue_item(-32768, -1);
		queue_item(1000, 500);
		wait_idle();

		// The unused mode code, with every padding bit of the write set.
		set_config(MODE_RESERVED, 16'sd4096, 16'sd4096, 16'sd4096, '1);
		queue_item(2048, -300);
		queue_item(-2048, 300);
		wait_idle();

		// Extreme coefficients drive the exponential and the products into saturation.
		set_config(elufb_pkg::MODE_FWD, -16'sd32768, 16'sd32767, -16'sd32768, '0);
		queue_item(-32768, 0);
		queue_item(-1, 0);
		queue_item(32767, 0);
		wait_idle();

		set_config(elufb_pkg::MODE_BWD_IN, -16'sd32768, 16'sd32767, -16'sd32768, '0);
		queue_item(-32768, -32768);
		queue_item(32767, -1);
		wait_idle();

		set_config(elufb_pkg::MODE_BWD_OUT, -16'sd32768, 16'sd32767, -16'sd32768, '0);
		queue_item(32767, -32768);
		queue_item(-32768, 0);
		wait_idle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			set_config(MW'($urandom_range(0, 3)), rand_coef(), rand_coef(), rand_coef(),
				(CDW - MW)'($urandom));
			if (ph == RANDOM_PHASES - 1) begin
				quiet = 1'b1;
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end else begin
				send_idle_pct = rand_idle_pct();
				recv_idle_pct = rand_idle_pct();
			end
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				queue_item(rand_data(), rand_data());
			end
			wait_idle();
		end

		if (error_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
